>>> hdl/vertex_transform_unit_defines.svh
// assertion helpers used by the checker file
`ifndef VERTEX_TRANSFORM_UNIT_DEFINES_SVH
`define VERTEX_TRANSFORM_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define VTU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vtu assertion failed");

// next-cycle implication
`define VTU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vtu assertion failed");

`endif

>>> hdl/vtu_pkg.sv
`timescale 1ns / 1ps
package vtu_pkg;
  localparam int DATA_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * DATA_BITS;
  localparam int TERM_W    = PROD_W - FRAC_BITS;
  localparam int SUM_W     = TERM_W + 2;
  localparam int MAG_W     = SUM_W;
  localparam int QBITS     = DATA_BITS + 1;
  localparam int DIV_W     = MAG_W + FRAC_BITS;
  localparam int NUM_CFG   = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] CMD_POINT = 2'd0;
  localparam logic [1:0] CMD_HOMOG = 2'd1;
  localparam logic [1:0] CMD_VEC   = 2'd2;

  localparam logic [DATA_BITS-1:0] ONE_Q = DATA_BITS'(1) << FRAC_BITS;
  localparam logic [DATA_BITS-1:0] DMAX  = {1'b0, {(DATA_BITS-1){1'b1}}};
  localparam logic [DATA_BITS-1:0] DMIN  = {1'b1, {(DATA_BITS-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_DMAX =
    {{(SUM_W-DATA_BITS+1){1'b0}}, {(DATA_BITS-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_DMIN =
    {{(SUM_W-DATA_BITS+1){1'b1}}, {(DATA_BITS-1){1'b0}}};
  localparam logic [QBITS-1:0] Q_LIM = QBITS'(1) << (DATA_BITS - 1);

  typedef logic [3:0][DATA_BITS-1:0] vec4_t;

  typedef struct packed {
    logic                 vec;
    logic                 hom;
    logic                 n_sign;
    logic                 n_nz;
    logic                 w_sign;
    logic                 w_zero;
    logic [DATA_BITS-1:0] vec_val;
  } div_meta_t;
endpackage

>>> hdl/vtu_lane.sv
`timescale 1ns / 1ps
module vtu_lane (
  input  logic                            clk,
  input  logic                            en,
  input  vtu_pkg::vec4_t                  row,
  input  vtu_pkg::vec4_t                  vin,
  input  logic                            mask3,
  output logic signed [vtu_pkg::SUM_W-1:0] sum_r
);
  import vtu_pkg::*;

  logic signed [PROD_W-1:0] prod_r [4];
  logic signed [PROD_W-1:0] prod_nxt [4];
  logic                     mask3_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [PROD_W-1:0] shifted;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod_nxt[i] = PROD_W'($signed(row[i])) * PROD_W'($signed(vin[i]));
    end
  end

  always_comb begin
    sum_nxt = '0;
    shifted = '0;
    for (int i = 0; i < 4; i++) begin
      shifted = prod_r[i] >>> FRAC_BITS;
      if (!(i == 3 && mask3_r)) begin
        sum_nxt = sum_nxt + SUM_W'($signed(shifted[TERM_W-1:0]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        prod_r[i] <= prod_nxt[i];
      end
      mask3_r <= mask3;
      sum_r   <= sum_nxt;
    end
  end
endmodule

>>> hdl/vtu_div.sv
`timescale 1ns / 1ps
module vtu_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [vtu_pkg::MAG_W-1:0]   an,
  input  logic [vtu_pkg::MAG_W-1:0]   aw,
  input  vtu_pkg::div_meta_t          meta_in,
  output logic                        out_vld,
  output logic [vtu_pkg::QBITS-1:0]   q,
  output logic                        ovf,
  output vtu_pkg::div_meta_t          meta_out
);
  import vtu_pkg::*;

  logic             vld_r  [QBITS+1];
  logic [MAG_W-1:0] rem_r  [QBITS+1];
  logic [MAG_W-1:0] aw_r   [QBITS+1];
  logic [DIV_W-1:0] d_r    [QBITS+1];
  logic [QBITS-1:0] q_r    [QBITS+1];
  logic             ovf_r  [QBITS+1];
  div_meta_t        meta_r [QBITS+1];

  logic [DIV_W-1:0] d_in;
  logic [DIV_W-1:0] hi_in;
  logic             ovf_in;

  assign d_in   = {an, {FRAC_BITS{1'b0}}};
  assign hi_in  = d_in >> QBITS;
  assign ovf_in = hi_in >= DIV_W'(aw);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= ovf_in ? '0 : hi_in[MAG_W-1:0];
      aw_r[0]   <= aw;
      d_r[0]    <= d_in;
      q_r[0]    <= '0;
      ovf_r[0]  <= ovf_in;
      meta_r[0] <= meta_in;
    end
  end

  for (genvar k = 1; k <= QBITS; k++) begin : g_stage
    logic [MAG_W:0] trial;
    logic           ge;
    assign trial = {rem_r[k-1], d_r[k-1][QBITS-k]};
    assign ge    = trial >= {1'b0, aw_r[k-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? MAG_W'(trial - {1'b0, aw_r[k-1]}) : trial[MAG_W-1:0];
        aw_r[k]   <= aw_r[k-1];
        d_r[k]    <= d_r[k-1];
        q_r[k]    <= {q_r[k-1][QBITS-2:0], ge};
        ovf_r[k]  <= ovf_r[k-1];
        meta_r[k] <= meta_r[k-1];
      end
    end
  end

  assign out_vld  = vld_r[QBITS];
  assign q        = q_r[QBITS];
  assign ovf      = ovf_r[QBITS];
  assign meta_out = meta_r[QBITS];
endmodule

>>> hdl/vtu_merge.sv
`timescale 1ns / 1ps
module vtu_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [2:0][vtu_pkg::QBITS-1:0] q,
  input  logic [2:0]                    ovf,
  input  vtu_pkg::div_meta_t [2:0]      meta,
  output logic                          en,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [135:0]                  out_tdata
);
  import vtu_pkg::*;

  logic                 out_valid_r;
  logic [2:0][31:0]     res_r;
  logic [31:0]          w_r;
  logic                 fault_r;
  logic [2:0][DATA_BITS-1:0] res_nxt;
  logic [2:0]           flt;
  logic                 neg;

  always_comb begin
    flt = '0;
    neg = 1'b0;
    for (int i = 0; i < 3; i++) begin
      neg = meta[i].n_sign ^ meta[i].w_sign;
      res_nxt[i] = q[i][DATA_BITS-1:0];
      if (meta[i].vec) begin
        res_nxt[i] = meta[i].vec_val;
      end else if (meta[i].w_zero) begin
        flt[i] = 1'b1;
        if (meta[i].n_sign) res_nxt[i] = DMIN;
        else if (meta[i].n_nz) res_nxt[i] = DMAX;
        else res_nxt[i] = '0;
      end else if (neg) begin
        if (ovf[i] || q[i] > Q_LIM) begin
          flt[i] = 1'b1;
          res_nxt[i] = DMIN;
        end else begin
          res_nxt[i] = DATA_BITS'(-q[i]);
        end
      end else begin
        if (ovf[i] || q[i] >= Q_LIM) begin
          flt[i] = 1'b1;
          res_nxt[i] = DMAX;
        end
      end
    end
  end

  assign en = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        res_r[i] <= 32'($signed(res_nxt[i]));
      end
      w_r     <= meta[0].hom ? 32'(ONE_Q) : 32'd0;
      fault_r <= |flt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, fault_r, w_r, res_r[2], res_r[1], res_r[0]};
endmodule

>>> hdl/vertex_transform_unit.sv
`timescale 1ns / 1ps
// 4x4 fixed-point vertex transform. Takes one vertex per clock and delivers one
// result per clock unless out_tready stalls it. Four row lanes, each of which
// holds four multipliers and a row adder, feed bit-per-stage restoring dividers.
// When the output register is held by out_tready low, the whole pipeline holds
// and in_tready drops. The user must write matrix rows through cfg_we/cfg_index/
// cfg_wdata only while no transaction is in flight; the block does not enforce it.
module vertex_transform_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // cmd[1:0], in_x[33:2], in_y[65:34], in_z[97:66], in_w[129:98]
  input  logic [135:0]                      in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96], div_fault[128]
  output logic [135:0]                      out_tdata,
  input  logic                              cfg_we,
  input  logic [vtu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [63:0]                       cfg_wdata
);
  import vtu_pkg::*;

  logic [63:0]        cfg_r [NUM_CFG];
  logic               en;
  logic [1:0]         cmd;
  vec4_t              vin;
  vec4_t              row [4];
  logic               v1_r, v2_r;
  logic [1:0]         c1_r, c2_r;
  logic signed [SUM_W-1:0] sum [4];
  logic [2:0]         dvld;
  logic [2:0][QBITS-1:0] dq;
  logic [2:0]         dovf;
  div_meta_t [2:0]    dmeta;
  logic [MAG_W-1:0]   aw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        cfg_r[i] <= '0;
      end
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  assign cmd = in_tdata[1:0];
  assign vin[0] = in_tdata[2 +: DATA_BITS];
  assign vin[1] = in_tdata[34 +: DATA_BITS];
  assign vin[2] = in_tdata[66 +: DATA_BITS];
  assign vin[3] = (cmd == CMD_POINT) ? ONE_Q : in_tdata[98 +: DATA_BITS];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      row[r][0] = cfg_r[2*r][32 +: DATA_BITS];
      row[r][1] = cfg_r[2*r][0 +: DATA_BITS];
      row[r][2] = cfg_r[2*r+1][32 +: DATA_BITS];
      row[r][3] = cfg_r[2*r+1][0 +: DATA_BITS];
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_lane
    vtu_lane u_lane (
      .clk   (clk),
      .en    (en),
      .row   (row[r]),
      .vin   (vin),
      .mask3 (cmd[1]),
      .sum_r (sum[r])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r <= cmd;
      c2_r <= c1_r;
    end
  end

  assign aw = sum[3][SUM_W-1] ? MAG_W'(-sum[3]) : MAG_W'(sum[3]);

  for (genvar k = 0; k < 3; k++) begin : g_div
    div_meta_t        meta;
    logic [MAG_W-1:0] an;
    logic [DATA_BITS-1:0] vsat;

    always_comb begin
      if (sum[k] > SUM_DMAX) vsat = DMAX;
      else if (sum[k] < SUM_DMIN) vsat = DMIN;
      else vsat = sum[k][DATA_BITS-1:0];
    end

    assign an = sum[k][SUM_W-1] ? MAG_W'(-sum[k]) : MAG_W'(sum[k]);
    assign meta.vec     = c2_r[1];
    assign meta.hom     = (c2_r == CMD_HOMOG);
    assign meta.n_sign  = sum[k][SUM_W-1];
    assign meta.n_nz    = |sum[k];
    assign meta.w_sign  = sum[3][SUM_W-1];
    assign meta.w_zero  = ~|sum[3];
    assign meta.vec_val = vsat;

    vtu_div u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (v2_r),
      .an       (an),
      .aw       (aw),
      .meta_in  (meta),
      .out_vld  (dvld[k]),
      .q        (dq[k]),
      .ovf      (dovf[k]),
      .meta_out (dmeta[k])
    );
  end

  vtu_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (dvld[0]),
    .q          (dq),
    .ovf        (dovf),
    .meta       (dmeta),
    .en         (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  assign in_tready = en;
endmodule

>>> hdl/vtu_checker.sv
`timescale 1ns / 1ps
`include "vertex_transform_unit_defines.svh"
module vtu_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata
);
  import vtu_pkg::*;

  `VTU_ASSERT_IMP(a_w_code, out_tvalid && in_tvalid, (out_tdata[127:96] == 32'd0 || out_tdata[127:96] == 32'(ONE_Q)))
  `VTU_ASSERT_IMP(a_ready_when_empty, !out_tvalid, in_tready)
  `VTU_ASSERT_NXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule

bind vertex_transform_unit vtu_checker u_vtu_checker (.*);
